### rtl/rhc_pkg.sv
package rhc_pkg;

   localparam int BINS = 32;
   localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;

   localparam int DATA_W = 32;
   localparam int BYTE_W = 8;
   localparam int PROD_W = 2 * DATA_W;
   // The scale product carries 24 fraction bits, which the bin index drops.
   localparam int FRAC_W = 24;
   localparam int IDX_W = PROD_W - FRAC_W;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_SCALE = 1'b1;

   localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};
   localparam logic [BYTE_W-1:0] LOWEST_RESET = {BYTE_W{1'b1}};

   typedef struct packed {
      logic             reject;
      logic [BIN_W-1:0] bin;
   } bin_item_type;

endpackage

### rtl/rhc_req_if.sv
interface rhc_req_if import rhc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [DATA_W-1:0] sample_value;
   logic [BYTE_W-1:0]        direct_bin;

   modport source (output valid, mode, sample_value, direct_bin, input ready);
   modport sink (input valid, mode, sample_value, direct_bin, output ready);
endinterface

### rtl/rhc_rsp_if.sv
interface rhc_rsp_if import rhc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] bin;
   logic [DATA_W-1:0] bin_count;
   logic [DATA_W-1:0] total_count;
   logic [DATA_W-1:0] peak_count;
   logic [BYTE_W-1:0] lowest_bin;
   logic [BYTE_W-1:0] highest_bin;
   logic              rejected;

   modport source (output valid, bin, bin_count, total_count, peak_count, lowest_bin,
                   highest_bin, rejected, input ready);
   modport sink (input valid, bin, bin_count, total_count, peak_count, lowest_bin,
                 highest_bin, rejected, output ready);
endinterface

### rtl/rhc_binner.sv
module rhc_binner import rhc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     in_mode,
   input  logic signed [DATA_W-1:0] in_sample,
   input  logic [BYTE_W-1:0]        in_direct,
   input  logic [DATA_W-1:0]        range_low,
   input  logic [DATA_W-1:0]        bin_scale,
   output logic                     out_valid,
   input  logic                     out_ready,
   output bin_item_type             out_item
);

   // Stage 1: offset from the range start.
   logic              v1_ff;
   logic              mode1_ff;
   logic [BYTE_W-1:0] direct1_ff;
   logic              pos1_ff;
   logic [DATA_W-1:0] diff1_ff;
   // Stage 2: scaled offset.
   logic              v2_ff;
   logic              mode2_ff;
   logic [BYTE_W-1:0] direct2_ff;
   logic              pos2_ff;
   logic [IDX_W-1:0]  idx2_ff;
   // Stage 3: clamped bin.
   logic              v3_ff;
   bin_item_type      item3_ff;
   bin_item_type      item3_in;

   logic              s1_adv, s2_adv, s3_adv;
   logic [DATA_W:0]   diff;
   logic [PROD_W-1:0] prod;

   assign s3_adv   = !v3_ff || out_ready;
   assign s2_adv   = !v2_ff || s3_adv;
   assign s1_adv   = !v1_ff || s2_adv;
   assign in_ready = s1_adv;

   assign diff = {in_sample[DATA_W-1], in_sample} - {range_low[DATA_W-1], range_low};
   assign prod = {{DATA_W{1'b0}}, diff1_ff} * {{DATA_W{1'b0}}, bin_scale};

   always_comb begin
      item3_in = '0;
      if (mode2_ff) begin
         item3_in.reject = ({1'b0, direct2_ff} >= (BYTE_W+1)'(BINS));
         item3_in.bin    = direct2_ff[BIN_W-1:0];
      end else if (!pos2_ff) begin
         item3_in.bin = '0;
      end else if (idx2_ff > IDX_W'(BINS - 1)) begin
         item3_in.bin = BIN_W'(BINS - 1);
      end else begin
         item3_in.bin = idx2_ff[BIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s1_adv) v1_ff <= in_valid;
         if (s2_adv) v2_ff <= v1_ff;
         if (s3_adv) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mode1_ff   <= in_mode;
         direct1_ff <= in_direct;
         // A zero or negative offset lands in bin 0.
         pos1_ff    <= !diff[DATA_W] && (diff[DATA_W-1:0] != '0);
         diff1_ff   <= diff[DATA_W-1:0];
      end
      if (s2_adv) begin
         mode2_ff   <= mode1_ff;
         direct2_ff <= direct1_ff;
         pos2_ff    <= pos1_ff;
         idx2_ff    <= prod[PROD_W-1:FRAC_W];
      end
      if (s3_adv) begin
         item3_ff <= item3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;

endmodule

### rtl/range_histogram_counter_unit.sv
// Histogram engine: each item bins a Q.8 sample against the range_low and bin_scale
// registers (or takes direct_bin as the bin), increments that bin's saturating count
// and returns one result with the bin, its new count, the saturating total, the peak
// bin count and the lowest and highest bins used. A rejected direct bin changes
// nothing. One item is accepted every cycle while the result side keeps up. An item
// enters the first of five register stages at the edge that accepts it: three binning
// stages (offset, scale multiply, clamp), one read-modify-write stage on the count
// memory, and the output register. Counts live in a synchronous-read RAM; an item
// that hits the same bin as the one ahead of it takes the fresh count by forwarding.
// Per-entry valid bits make the store read as zero after reset, so no clearing pass
// is needed.
module range_histogram_counter_unit import rhc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rhc_req_if.sink                req_chan,
   rhc_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   logic [DATA_W-1:0] range_low_ff;
   logic [DATA_W-1:0] bin_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff <= '0;
         bin_scale_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_LOW: range_low_ff <= csr_wdata;
            CSR_BIN_SCALE: bin_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic         a_valid;
   logic         m_adv;
   bin_item_type a_item;

   rhc_binner u_binner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_mode   (req_chan.mode),
      .in_sample (req_chan.sample_value),
      .in_direct (req_chan.direct_bin),
      .range_low (range_low_ff),
      .bin_scale (bin_scale_ff),
      .out_valid (a_valid),
      .out_ready (m_adv),
      .out_item  (a_item)
   );

   logic [DATA_W-1:0] cnt_mem [BINS];
   logic [BINS-1:0]   vld_ff;

   logic              vm_ff;
   bin_item_type      itm_ff;
   logic [DATA_W-1:0] rd_ff;
   logic              rdv_ff;
   logic              fwd_ff;
   logic [DATA_W-1:0] fwd_data_ff;

   logic [DATA_W-1:0] total_ff, total_in;
   logic [DATA_W-1:0] peak_ff, peak_in;
   logic [BYTE_W-1:0] lowest_ff, lowest_in;
   logic [BYTE_W-1:0] highest_ff, highest_in;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_bin_ff;
   logic [DATA_W-1:0] rsp_count_ff;
   logic              rsp_rej_ff;

   logic              out_adv;
   logic              m_fire;
   logic              m_write;
   logic [DATA_W-1:0] old_count;
   logic [DATA_W-1:0] new_count;
   logic [BYTE_W-1:0] m_bin;

   assign out_adv = !rsp_valid_ff || rsp_chan.ready;
   assign m_adv   = !vm_ff || out_adv;
   assign m_fire  = vm_ff && out_adv;
   assign m_write = m_fire && !itm_ff.reject;
   assign m_bin   = BYTE_W'(itm_ff.bin);

   always_comb begin
      if (fwd_ff) begin
         old_count = fwd_data_ff;
      end else if (rdv_ff) begin
         old_count = rd_ff;
      end else begin
         old_count = '0;
      end
      new_count  = (old_count == COUNT_MAX) ? old_count : old_count + DATA_W'(1);
      total_in   = (total_ff == COUNT_MAX) ? total_ff : total_ff + DATA_W'(1);
      peak_in    = (new_count > peak_ff) ? new_count : peak_ff;
      lowest_in  = (m_bin < lowest_ff) ? m_bin : lowest_ff;
      highest_in = (m_bin > highest_ff) ? m_bin : highest_ff;
   end

   // Count memory: read when an item enters the update stage, written as it leaves.
   always_ff @(posedge clock) begin
      if (m_write) begin
         cnt_mem[itm_ff.bin] <= new_count;
      end
      if (m_adv) begin
         rd_ff <= cnt_mem[a_item.bin];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rdv_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         if (m_write) begin
            vld_ff[itm_ff.bin] <= 1'b1;
         end
         if (m_adv) begin
            rdv_ff <= vld_ff[a_item.bin];
            // The read at this edge misses the write of the same edge.
            fwd_ff <= m_write && (a_item.bin == itm_ff.bin);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_adv) begin
         fwd_data_ff <= new_count;
         itm_ff      <= a_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         peak_ff      <= '0;
         lowest_ff    <= LOWEST_RESET;
         highest_ff   <= '0;
      end else begin
         if (m_adv) vm_ff <= a_valid;
         if (out_adv) rsp_valid_ff <= vm_ff;
         if (m_write) begin
            total_ff   <= total_in;
            peak_ff    <= peak_in;
            lowest_ff  <= lowest_in;
            highest_ff <= highest_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_fire) begin
         rsp_rej_ff   <= itm_ff.reject;
         rsp_bin_ff   <= itm_ff.reject ? '0 : m_bin;
         rsp_count_ff <= itm_ff.reject ? '0 : new_count;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bin         = rsp_bin_ff;
   assign rsp_chan.bin_count   = rsp_count_ff;
   assign rsp_chan.total_count = total_ff;
   assign rsp_chan.peak_count  = peak_ff;
   assign rsp_chan.lowest_bin  = lowest_ff;
   assign rsp_chan.highest_bin = highest_ff;
   assign rsp_chan.rejected    = rsp_rej_ff;

endmodule

### rtl/rhc_checker.sv
module rhc_checker import rhc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_bin,
   input logic [DATA_W-1:0] rsp_bin_count,
   input logic [DATA_W-1:0] rsp_total_count,
   input logic [DATA_W-1:0] rsp_peak_count,
   input logic [BYTE_W-1:0] rsp_lowest_bin,
   input logic [BYTE_W-1:0] rsp_highest_bin,
   input logic              rsp_rejected
);

   // A waiting item stays offered until it is taken.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result item dropped while stalled");

   // A rejected item reports no bin and no count.
   property p_reject_clean;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_rejected |-> rsp_bin == '0 && rsp_bin_count == '0;
   endproperty
   a_reject_clean: assert property (p_reject_clean) else $error("rejected item carries a bin");

   // An updated bin's count is nonzero and bounded by the peak and the total.
   property p_count_bounds;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_rejected |->
            rsp_bin_count != '0 && rsp_bin_count <= rsp_peak_count &&
            rsp_bin_count <= rsp_total_count;
   endproperty
   a_count_bounds: assert property (p_count_bounds) else $error("bin count out of bounds");

   // The updated bin lies inside the range of bins used so far.
   property p_bin_span;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_rejected |->
            rsp_lowest_bin <= rsp_bin && rsp_bin <= rsp_highest_bin &&
            rsp_bin < BYTE_W'(BINS);
   endproperty
   a_bin_span: assert property (p_bin_span) else $error("bin outside used span");

endmodule

bind range_histogram_counter_unit rhc_checker u_rhc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bin         (rsp_chan.bin),
   .rsp_bin_count   (rsp_chan.bin_count),
   .rsp_total_count (rsp_chan.total_count),
   .rsp_peak_count  (rsp_chan.peak_count),
   .rsp_lowest_bin  (rsp_chan.lowest_bin),
   .rsp_highest_bin (rsp_chan.highest_bin),
   .rsp_rejected    (rsp_chan.rejected)
);
